// ----- rtl/psg_pkg.sv -----
// Shared types, constants and the arctangent table of the phase sine/cosine generator.
// No dependencies; every other file in rtl imports this package.
package psg_pkg;

   localparam int TIME_W     = 32;
   localparam int FREQ_W     = 32;
   localparam int OUT_W      = 24;
   localparam int VEC_W      = 33;
   localparam int ATAN_COUNT = 32;
   localparam int OUT_SHIFT  = 8;

   localparam logic signed [VEC_W-1:0]   GAIN_START = 33'sd652032874;
   localparam logic signed [VEC_W:0]     ROUND_HALF = 34'sd128;
   localparam logic signed [VEC_W:0]     OUT_ONE    = 34'sd4194304;

   typedef logic signed [VEC_W-1:0] vec_type;

   typedef struct packed {
      logic       valid;
      logic       last;
      logic [1:0] quad;
   } psg_ctl_type;

   typedef struct packed {
      vec_type x;
      vec_type y;
      vec_type z;
   } psg_vec_type;

   // atan(2^-i) in 2^32 units per turn, rounded
   function automatic vec_type atan_turn(input logic [4:0] idx);
      vec_type r;
      case (idx)
         5'd0:  r = 33'sd536870912;
         5'd1:  r = 33'sd316933406;
         5'd2:  r = 33'sd167458907;
         5'd3:  r = 33'sd85004756;
         5'd4:  r = 33'sd42667331;
         5'd5:  r = 33'sd21354465;
         5'd6:  r = 33'sd10679838;
         5'd7:  r = 33'sd5340245;
         5'd8:  r = 33'sd2670163;
         5'd9:  r = 33'sd1335087;
         5'd10: r = 33'sd667544;
         5'd11: r = 33'sd333772;
         5'd12: r = 33'sd166886;
         5'd13: r = 33'sd83443;
         5'd14: r = 33'sd41722;
         5'd15: r = 33'sd20861;
         5'd16: r = 33'sd10430;
         5'd17: r = 33'sd5215;
         5'd18: r = 33'sd2608;
         5'd19: r = 33'sd1304;
         5'd20: r = 33'sd652;
         5'd21: r = 33'sd326;
         5'd22: r = 33'sd163;
         5'd23: r = 33'sd81;
         5'd24: r = 33'sd41;
         5'd25: r = 33'sd20;
         5'd26: r = 33'sd10;
         5'd27: r = 33'sd5;
         5'd28: r = 33'sd3;
         5'd29: r = 33'sd1;
         5'd30: r = 33'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/psg_phase.sv -----
// Phase front end: time x frequency product (fraction only), truncation, quadrant reduction.
// Two register stages. Depends on psg_pkg.
module psg_phase #(
   parameter int PHASE_BITS = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            enable,
   input  logic                            in_valid,
   input  logic                            in_last,
   input  logic [psg_pkg::TIME_W-1:0]      sample_time,
   input  logic [psg_pkg::FREQ_W-1:0]      frequency,
   output psg_pkg::psg_ctl_type            ctl_out,
   output psg_pkg::psg_vec_type            vec_out
);
   import psg_pkg::*;

   localparam int DROP = FREQ_W - PHASE_BITS;

   logic [FREQ_W-1:0]   frac_ff, frac_in, phase;
   logic                valid_ff, last_ff;
   psg_ctl_type         ctl_ff, ctl_in;
   psg_vec_type         vec_ff, vec_in;

   // only the low word of the product is the fraction of a cycle
   assign frac_in = sample_time * frequency;

   always_comb begin
      phase        = (frac_ff >> DROP) << DROP;
      ctl_in.valid = valid_ff;
      ctl_in.last  = last_ff;
      // residue of an eighth of a turn or more moves to the next quadrant
      ctl_in.quad  = phase[FREQ_W-1:FREQ_W-2] + {1'b0, phase[FREQ_W-3]};
      vec_in.x     = GAIN_START;
      vec_in.y     = '0;
      vec_in.z     = vec_type'(signed'(phase[FREQ_W-3:0]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         ctl_ff.valid <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
         ctl_ff   <= ctl_in;
         frac_ff  <= frac_in;
         last_ff  <= in_last;
         vec_ff   <= vec_in;
      end
   end

   assign ctl_out = ctl_ff;
   assign vec_out = vec_ff;

endmodule

// ----- rtl/psg_cordic_stage.sv -----
// One rotation-mode CORDIC iteration with its own pipeline register.
// Depends on psg_pkg (vector types and arctangent table).
module psg_cordic_stage #(
   parameter int STEP = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  psg_pkg::psg_ctl_type ctl_in,
   input  psg_pkg::psg_vec_type vec_in,
   output psg_pkg::psg_ctl_type ctl_out,
   output psg_pkg::psg_vec_type vec_out
);
   import psg_pkg::*;

   psg_ctl_type ctl_ff;
   psg_vec_type vec_ff, vec_nx_in;
   vec_type     dx, dy, angle;

   always_comb begin
      dx    = vec_in.y >>> STEP;
      dy    = vec_in.x >>> STEP;
      angle = atan_turn(5'(STEP));
      if (!vec_in.z[VEC_W-1]) begin
         vec_nx_in.x = vec_in.x - dx;
         vec_nx_in.y = vec_in.y + dy;
         vec_nx_in.z = vec_in.z - angle;
      end else begin
         vec_nx_in.x = vec_in.x + dx;
         vec_nx_in.y = vec_in.y - dy;
         vec_nx_in.z = vec_in.z + angle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (enable) begin
         ctl_ff <= ctl_in;
         vec_ff <= vec_nx_in;
      end
   end

   assign ctl_out = ctl_ff;
   assign vec_out = vec_ff;

endmodule

// ----- rtl/psg_output.sv -----
// Output stage: quadrant mapping, rounding to 1.0 = 2^22, saturation, result register.
// Depends on psg_pkg.
module psg_output (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          enable,
   input  psg_pkg::psg_ctl_type          ctl_in,
   input  psg_pkg::psg_vec_type          vec_in,
   output logic                          out_valid,
   output logic                          out_last,
   output logic [psg_pkg::OUT_W-1:0]     out_sine,
   output logic [psg_pkg::OUT_W-1:0]     out_cosine
);
   import psg_pkg::*;

   vec_type          cos_v, sin_v;
   logic             valid_ff, last_ff;
   logic [OUT_W-1:0] sine_ff, sine_in, cosine_ff, cosine_in;

   function automatic logic [OUT_W-1:0] to_field(input vec_type v);
      logic signed [VEC_W:0] s;
      logic signed [VEC_W:0] r;
      s = {v[VEC_W-1], v} + ROUND_HALF;
      r = s >>> OUT_SHIFT;
      if (r > OUT_ONE) begin
         r = OUT_ONE;
      end else if (r < -OUT_ONE) begin
         r = -OUT_ONE;
      end
      return r[OUT_W-1:0];
   endfunction

   always_comb begin
      case (ctl_in.quad)
         2'd0: begin
            cos_v = vec_in.x;
            sin_v = vec_in.y;
         end
         2'd1: begin
            cos_v = -vec_in.y;
            sin_v = vec_in.x;
         end
         2'd2: begin
            cos_v = -vec_in.x;
            sin_v = -vec_in.y;
         end
         default: begin
            cos_v = vec_in.y;
            sin_v = -vec_in.x;
         end
      endcase
      sine_in   = to_field(sin_v);
      cosine_in = to_field(cos_v);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= ctl_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         last_ff   <= ctl_in.last;
         sine_ff   <= sine_in;
         cosine_ff <= cosine_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_last   = last_ff;
   assign out_sine   = sine_ff;
   assign out_cosine = cosine_ff;

   a_sine_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> ($signed(sine_ff) <= 24'sd4194304 && $signed(sine_ff) >= -24'sd4194304))
      else $error("sine out of range");

   a_cosine_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> ($signed(cosine_ff) <= 24'sd4194304 && $signed(cosine_ff) >= -24'sd4194304))
      else $error("cosine out of range");

   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> !valid_ff)
      else $error("result valid after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !enable |=> $stable(valid_ff) && $stable(sine_ff) && $stable(cosine_ff))
      else $error("output stage moved during stall");

endmodule

// ----- rtl/phase_sincos_generator.sv -----
// Top level of the phase sine/cosine generator: CSR, phase front end, CORDIC pipe, output.
// Depends on psg_pkg, psg_phase, psg_cordic_stage and psg_output.
//
//   channel  dir  tdata fields (low bit up)            tuser/tlast
//   req_     in   [31:0] sample_time                   tlast = last_in
//   rsp_     out  [23:0] sine, [47:24] cosine          tlast = last_out
//   csr_     in   [31:0] frequency (Q0.32)             -
//
// One transaction per cycle sustained while results are accepted; the registered steps are the
// product, phase reduction, one register per CORDIC iteration and output rounding.
// Synchronous reset clears all valid bits and frequency to 0.
// The whole pipe advances together; it holds only while a result sits unaccepted.
// csr_ is always ready and must be written only while the pipe is empty.
module phase_sincos_generator #(
   parameter int PHASE_BITS   = 24,
   parameter int APPROX_STEPS = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] sample_time
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [23:0] sine, [47:24] cosine
   output logic        rsp_tlast,
   input  logic        csr_tvalid,
   output logic        csr_tready,
   input  logic [31:0] csr_tdata    // [31:0] frequency
);
   import psg_pkg::*;

   logic             enable;
   logic [FREQ_W-1:0] frequency_ff, frequency_in;
   logic [OUT_W-1:0] sine, cosine;
   psg_ctl_type      ctl_pipe [APPROX_STEPS+1];
   psg_vec_type      vec_pipe [APPROX_STEPS+1];

   assign enable       = !rsp_tvalid || rsp_tready;
   assign req_tready   = enable;
   assign csr_tready   = 1'b1;
   assign frequency_in = (csr_tvalid && csr_tready) ? csr_tdata : frequency_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frequency_ff <= '0;
      end else begin
         frequency_ff <= frequency_in;
      end
   end

   psg_phase #(
      .PHASE_BITS (PHASE_BITS)
   ) u_phase (
      .clock       (clock),
      .reset       (reset),
      .enable      (enable),
      .in_valid    (req_tvalid),
      .in_last     (req_tlast),
      .sample_time (req_tdata),
      .frequency   (frequency_ff),
      .ctl_out     (ctl_pipe[0]),
      .vec_out     (vec_pipe[0])
   );

   for (genvar i = 0; i < APPROX_STEPS; i++) begin : g_step
      psg_cordic_stage #(
         .STEP (i)
      ) u_stage (
         .clock   (clock),
         .reset   (reset),
         .enable  (enable),
         .ctl_in  (ctl_pipe[i]),
         .vec_in  (vec_pipe[i]),
         .ctl_out (ctl_pipe[i+1]),
         .vec_out (vec_pipe[i+1])
      );
   end

   psg_output u_output (
      .clock      (clock),
      .reset      (reset),
      .enable     (enable),
      .ctl_in     (ctl_pipe[APPROX_STEPS]),
      .vec_in     (vec_pipe[APPROX_STEPS]),
      .out_valid  (rsp_tvalid),
      .out_last   (rsp_tlast),
      .out_sine   (sine),
      .out_cosine (cosine)
   );

   assign rsp_tdata = {cosine, sine};

endmodule

// ----- sim/psg_checker.sv -----
`timescale 1ns / 100ps
// Checker for the phase sine/cosine generator: watches the csr_, req_ and rsp_ channels,
// predicts sine, cosine and last for every accepted sample and compares in order.
// Stand-alone; no dependency on the RTL beyond its port widths.
module psg_checker #(
   parameter int PHASE_BITS   = 24,
   parameter int APPROX_STEPS = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] sample_time
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,   // [23:0] sine, [47:24] cosine
   input  logic        rsp_tlast,
   input  logic        csr_tvalid,
   input  logic        csr_tready,
   input  logic [31:0] csr_tdata,   // [31:0] frequency
   output int          fail_count,
   output int          pending
);

   localparam longint CORDIC_GAIN_START = 652032874;
   localparam longint Q22_ONE           = 4194304;

   typedef enum logic [1:0] {QUAD_0, QUAD_90, QUAD_180, QUAD_270} quadrant_type;

   typedef struct packed {
      logic [23:0] sine;
      logic [23:0] cosine;
      logic        last;
   } sincos_type;

   // atan(2^-i), 2^32 units per turn
   longint arctan_turns [0:31] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5, 3, 1, 1, 0
   };

   sincos_type  sincos_q [$];
   logic [31:0] frequency;

   function automatic logic [23:0] to_q22(input longint v);
      longint r;
      r = (v + 128) >>> 8;
      if (r > Q22_ONE)
         r = Q22_ONE;
      if (r < -Q22_ONE)
         r = -Q22_ONE;
      return r[23:0];
   endfunction

   function automatic sincos_type predict_sincos(input logic [31:0] sample_time,
                                                 input logic [31:0] freq,
                                                 input logic last);
      logic [31:0]  phase;
      quadrant_type quad;
      longint       x, y, z, dx, dy, c, s;
      int           i;
      sincos_type   r;
      phase = sample_time * freq;
      phase = (phase >> (32 - PHASE_BITS)) << (32 - PHASE_BITS);
      quad  = quadrant_type'(phase[31:30]);
      z     = phase[29:0];
      // upper half of a quadrant rotates from the next one
      if (z >= (longint'(1) << 29)) begin
         z    = z - (longint'(1) << 30);
         quad = quadrant_type'(quad + 2'd1);
      end
      x = CORDIC_GAIN_START;
      y = 0;
      for (i = 0; i < APPROX_STEPS && i < 32; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - arctan_turns[i];
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + arctan_turns[i];
         end
      end
      case (quad)
         QUAD_0: begin
            c = x;
            s = y;
         end
         QUAD_90: begin
            c = -y;
            s = x;
         end
         QUAD_180: begin
            c = -x;
            s = -y;
         end
         default: begin
            c = y;
            s = -x;
         end
      endcase
      r.sine   = to_q22(s);
      r.cosine = to_q22(c);
      r.last   = last;
      return r;
   endfunction

   task automatic compare_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin : monitor
      sincos_type want;
      if (reset) begin
         frequency = '0;
         sincos_q.delete();
      end else begin
         if (req_tvalid && req_tready)
            sincos_q.push_back(predict_sincos(req_tdata, frequency, req_tlast));
         if (csr_tvalid && csr_tready)
            frequency = csr_tdata;
         if (rsp_tvalid && rsp_tready) begin
            if (sincos_q.size() == 0) begin
               $error("result transaction with no sample outstanding");
               fail_count++;
            end else begin
               want = sincos_q.pop_front();
               compare_field("sine", $signed(want.sine), $signed(rsp_tdata[23:0]));
               compare_field("cosine", $signed(want.cosine), $signed(rsp_tdata[47:24]));
               compare_field("last", want.last, rsp_tlast);
            end
         end
      end
      pending = sincos_q.size();
   end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// Top of the phase sine/cosine generator testbench: clock, reset, stimulus and verdict.
// Depends on phase_sincos_generator (rtl) and psg_checker.
module testbench;

   localparam int PHASE_BITS   = 24;
   localparam int APPROX_STEPS = 24;
   localparam int LONG_HOLD    = 150;
   localparam int PHASE_ITEMS  = 200;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_tvalid = 1'b0;
   logic        csr_tready;
   logic [31:0] csr_tdata  = '0;

   int fail_count;
   int pending;
   int hold_cycles = 0;
   bit quiet       = 1'b0;

   phase_sincos_generator #(
      .PHASE_BITS   (PHASE_BITS),
      .APPROX_STEPS (APPROX_STEPS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata)
   );

   psg_checker #(
      .PHASE_BITS   (PHASE_BITS),
      .APPROX_STEPS (APPROX_STEPS)
   ) i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #6_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // result side: one long hold on request, otherwise random stall bursts until quiet is set
   initial begin
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_cycles) @(negedge clock);
            hold_cycles = 0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   task automatic push_sample(input logic [31:0] sample_time, input bit last, input int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sample_time;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      wait (pending == 0);
      @(negedge clock);
   endtask

   task automatic write_frequency(input logic [31:0] freq);
      csr_tvalid <= 1'b1;
      csr_tdata  <= freq;
      do @(posedge clock); while (!csr_tready);
      @(negedge clock);
      csr_tvalid <= 1'b0;
   endtask

   initial begin : stimulus
      logic [31:0] unit_times [0:12] = '{
         32'h0000_0000, 32'h0000_0001, 32'h0000_00FF, 32'h0000_0100,
         32'h1FFF_FFFF, 32'h2000_0000, 32'h4000_0000, 32'h6000_0000,
         32'h8000_0000, 32'hC000_0000, 32'hE000_0000, 32'h7FFF_FFFF,
         32'hFFFF_FFFF
      };
      logic [31:0] sample_time;
      logic [31:0] freq;
      logic [31:0] base;
      bit          last;
      int          gap;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // frequency still at its reset value of zero
      push_sample(32'h0000_0000, 1'b0, 0);
      push_sample(32'h7FFF_FFFF, 1'b0, 0);
      push_sample(32'h8000_0000, 1'b1, 0);
      drain_results();

      // unit frequency: the product equals time, so octant and quadrant edges are hit directly
      write_frequency(32'h0000_0001);
      for (int i = 0; i < 13; i++)
         push_sample(unit_times[i], i[0], 0);
      drain_results();

      write_frequency(32'h7FFF_FFFF);
      push_sample(32'h7FFF_FFFF, 1'b0, 0);
      push_sample(32'h8000_0000, 1'b1, 0);
      drain_results();

      write_frequency(32'h8000_0000);
      push_sample(32'hFFFF_FFFF, 1'b0, 0);
      push_sample(32'h8000_0000, 1'b0, 0);
      push_sample(32'h0000_0001, 1'b1, 0);
      drain_results();

      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            1:       freq = 32'h7FFF_FFFF;
            3:       freq = 32'h8000_0000;
            4:       freq = $urandom_range(1, 65535);
            5:       freq = 32'hFFFF_FFFF;
            6:       freq = 32'h0000_0000;
            default: freq = $urandom;
         endcase
         write_frequency(freq);
         if (ph == 2)
            hold_cycles = LONG_HOLD;
         if (ph == 7)
            quiet = 1'b1;
         base = $urandom;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (ph == 4 && n == PHASE_ITEMS / 2)
               drain_results();
            case ($urandom_range(0, 3))
               0:       sample_time = $urandom;
               1:       sample_time = base + n;
               2:       sample_time = $urandom_range(0, 8191) - 4096;
               default: sample_time = ($urandom_range(0, 1) ? 32'h7FFF_F000 : 32'h8000_0000)
                                      + $urandom_range(0, 4095);
            endcase
            last = ($urandom_range(0, 15) == 0) || (n == PHASE_ITEMS - 1);
            if (quiet || (ph == 2 && n < 60))
               gap = 0;
            else
               gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 14) : 0;
            push_sample(sample_time, last, gap);
         end
         drain_results();
      end

      repeat (40) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/psg_pkg.sv
rtl/psg_phase.sv
rtl/psg_cordic_stage.sv
rtl/psg_output.sv
rtl/phase_sincos_generator.sv
sim/psg_checker.sv
sim/testbench.sv
